// File: sv/swhr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; imported by the controller, decode and top-level modules.
package swhr_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned BIT_W   = 6;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Number of data bits in one sensor frame
	localparam logic [BIT_W-1:0] FRAME_BITS = 6'd40;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RISE   = 3'd4;

	// Configuration reset values
	localparam logic [15:0] RST_START_LOW = 16'd18000;
	localparam logic [7:0]  RST_RELEASE   = 8'd40;
	localparam logic [7:0]  RST_TIMEOUT   = 8'd85;
	localparam logic [7:0]  RST_THRESHOLD = 8'd30;
	localparam logic [11:0] RST_MAX_RISE  = 12'd50;

	// Line protocol phases
	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_START_LOW = 7'b0000010,
		PH_RELEASE   = 7'b0000100,
		PH_RESP_LOW  = 7'b0001000,
		PH_RESP_HIGH = 7'b0010000,
		PH_BIT_LOW   = 7'b0100000,
		PH_BIT_HIGH  = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [15:0] start_low_ticks;
		logic [7:0]  release_ticks;
		logic [7:0]  phase_timeout;
		logic [7:0]  one_threshold;
		logic [11:0] max_rise_tenths;
	} cfg_t;

	// Per-tick outcome of the line controller
	typedef struct packed {
		logic               drive_enable;
		logic               drive_level;
		logic               busy;
		logic               done;
		logic [FRAME_W-1:0] frame;
	} tick_res_t;

endpackage

// File: sv/swhr_ctrl.sv
`timescale 1ns / 1ps
// Line controller: start pulse generation, phase timing and bit capture.
// Depends on swhr_pkg.
module swhr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               line_level,
	input  logic               start_request,
	input  swhr_pkg::cfg_t     cfg,
	output swhr_pkg::tick_res_t res
);
	import swhr_pkg::*;

	typedef struct packed {
		phase_t              phase;
		logic [TICK_W-1:0]   tick;
		logic [BIT_W-1:0]    bitc;
		logic [FRAME_W-1:0]  frame;
		logic                done;
	} st_t;

	phase_t             phase_q;
	logic [TICK_W-1:0]  tick_q;
	logic [BIT_W-1:0]   bit_q;
	logic [FRAME_W-1:0] frame_q;
	st_t                st_nx;

	// Close the current phase and move to the next one
	function automatic st_t close_ph(st_t s, logic [TICK_W-1:0] cnt, logic [7:0] thr);
		st_t r;
		r = s;
		r.tick = '0;
		case (s.phase)
			PH_RESP_LOW:  r.phase = PH_RESP_HIGH;
			PH_RESP_HIGH: r.phase = PH_BIT_LOW;
			PH_BIT_LOW:   r.phase = PH_BIT_HIGH;
			PH_BIT_HIGH: begin
				r.frame = {s.frame[FRAME_W-2:0], (cnt > {8'd0, thr})};
				r.bitc  = s.bitc + 1'b1;
				if (r.bitc < FRAME_BITS) begin
					r.phase = PH_BIT_LOW;
				end else begin
					r.phase = PH_IDLE;
					r.done  = 1'b1;
				end
			end
			default: r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	// Work out one tick of the protocol
	always_comb begin
		st_t               s;
		logic              den;
		logic              dlev;
		logic              busy;
		logic              want_high;
		logic              sampling;
		logic [7:0]        lim;
		s.phase = phase_q;
		s.tick  = tick_q;
		s.bitc  = bit_q;
		s.frame = frame_q;
		s.done  = 1'b0;
		den     = 1'b0;
		dlev    = 1'b0;
		want_high = 1'b0;
		lim     = (cfg.phase_timeout == 8'd0) ? 8'd1 : cfg.phase_timeout;

		// drop unknown phase codes back to idle
		case (phase_q)
			PH_IDLE, PH_START_LOW, PH_RELEASE, PH_RESP_LOW,
			PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: s.phase = phase_q;
			default: s.phase = PH_IDLE;
		endcase

		if (s.phase == PH_IDLE && start_request) begin
			s.phase = PH_START_LOW;
			s.tick  = '0;
			s.bitc  = '0;
			s.frame = '0;
		end
		busy = (s.phase != PH_IDLE);

		// host start pulse: low stretch
		if (s.phase == PH_START_LOW) begin
			if (s.tick < cfg.start_low_ticks) begin
				den    = 1'b1;
				s.tick = s.tick + 1'b1;
			end
			if (s.tick >= cfg.start_low_ticks) begin
				s.phase = PH_RELEASE;
				s.tick  = '0;
			end
		end

		// host start pulse: high stretch before release
		if (s.phase == PH_RELEASE && !den) begin
			if (s.tick < {8'd0, cfg.release_ticks}) begin
				den    = 1'b1;
				dlev   = 1'b1;
				s.tick = s.tick + 1'b1;
			end
			if (s.tick >= {8'd0, cfg.release_ticks}) begin
				s.phase = PH_RESP_LOW;
				s.tick  = '0;
			end
		end

		// time the sensor phases on released ticks
		sampling = !den && (s.phase == PH_RESP_LOW || s.phase == PH_RESP_HIGH ||
			s.phase == PH_BIT_LOW || s.phase == PH_BIT_HIGH);
		if (sampling) begin
			want_high = (s.phase == PH_RESP_HIGH || s.phase == PH_BIT_HIGH);
			if (line_level != want_high) begin
				s = close_ph(s, s.tick, cfg.one_threshold);
			end
			if (!s.done) begin
				s.tick = s.tick + 1'b1;
				if (s.tick >= {8'd0, lim}) begin
					s = close_ph(s, s.tick, cfg.one_threshold);
				end
			end
		end

		st_nx            = s;
		res.drive_enable = den;
		res.drive_level  = dlev;
		res.busy         = busy;
		res.done         = s.done;
		res.frame        = s.frame;
	end

	// Advance state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			frame_q <= '0;
		end else if (accept) begin
			phase_q <= st_nx.phase;
			tick_q  <= st_nx.tick;
			bit_q   <= st_nx.bitc;
			frame_q <= st_nx.frame;
		end
	end

endmodule

// File: sv/swhr_decode.sv
`timescale 1ns / 1ps
// Frame decode: humidity, temperature, checksum and rise check, plus held results.
// Depends on swhr_pkg.
module swhr_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  swhr_pkg::tick_res_t         res,
	input  logic [11:0]                 max_rise_tenths,
	output logic [7:0]                  humidity,
	output logic [swhr_pkg::TEMP_W-1:0] temperature_tenths,
	output logic                        checksum_ok,
	output logic                        rise_plausible
);
	import swhr_pkg::*;

	logic [7:0]        hum_q;
	logic [TEMP_W-1:0] temp_q;
	logic              chk_q;
	logic              rise_q;
	logic [TEMP_W-1:0] last_temp_q;

	logic [7:0]          b0, b1, b2, b3, b4;
	logic [TEMP_W-1:0]   temp_nx;
	logic [9:0]          byte_sum;
	logic                chk_nx;
	logic signed [12:0]  diff;
	logic                rise_nx;

	// Split the frame and evaluate it
	always_comb begin
		b0       = res.frame[39:32];
		b1       = res.frame[31:24];
		b2       = res.frame[23:16];
		b3       = res.frame[15:8];
		b4       = res.frame[7:0];
		temp_nx  = {1'b0, b2, 3'b000} + {3'b000, b2, 1'b0} + {4'd0, b3};
		byte_sum = {2'b00, b0} + {2'b00, b1} + {2'b00, b2} + {2'b00, b3};
		chk_nx   = (byte_sum[7:0] == b4);
		diff     = $signed({1'b0, temp_nx}) - $signed({1'b0, last_temp_q});
		rise_nx  = (diff < $signed({1'b0, max_rise_tenths}));
	end

	// Show fresh values on the completing tick, else the held ones
	assign humidity           = res.done ? b0 : hum_q;
	assign temperature_tenths = res.done ? temp_nx : temp_q;
	assign checksum_ok        = res.done ? chk_nx : chk_q;
	assign rise_plausible     = res.done ? rise_nx : rise_q;

	// Hold results of the last completed reading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hum_q       <= '0;
			temp_q      <= '0;
			chk_q       <= 1'b0;
			rise_q      <= 1'b0;
			last_temp_q <= '0;
		end else if (accept && res.done) begin
			hum_q       <= b0;
			temp_q      <= temp_nx;
			chk_q       <= chk_nx;
			rise_q      <= rise_nx;
			last_temp_q <= temp_nx;
		end
	end

endmodule

// File: sv/single_wire_humidity_sensor_reader_top.sv
`timescale 1ns / 1ps
// Top level of the single-wire humidity sensor reader: config registers and output register.
// Depends on swhr_pkg, swhr_ctrl and swhr_decode.
//
//   channel  handshake            payload
//   in       in_valid / in_stall   line_level, start_request
//   out      out_valid / out_stall drive_enable, drive_level, busy_res, reading_done,
//                                  humidity, temperature_tenths, checksum_ok, rise_plausible
//   cfg      cfg_write             cfg_index, cfg_data
//
// One tick transaction is taken per cycle while in_stall is low; its result appears in the next cycle.
// All work for a tick runs between the controller state and the output register.
// in_stall rises only while a result sits in the output register and out_stall is high.
// Reset clears the controller to idle, held results to zero and config to defaults.
module single_wire_humidity_sensor_reader_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                line_level,
	input  logic                                start_request,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                drive_enable,
	output logic                                drive_level,
	output logic                                busy_res,
	output logic                                reading_done,
	output logic [7:0]                          humidity,
	output logic [swhr_pkg::TEMP_W-1:0]         temperature_tenths,
	output logic                                checksum_ok,
	output logic                                rise_plausible,
	input  logic                                cfg_write,
	input  logic [swhr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swhr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import swhr_pkg::*;

	cfg_t              cfg_q;
	tick_res_t         res;
	logic              accept;
	logic [7:0]        hum_nx;
	logic [TEMP_W-1:0] temp_nx;
	logic              chk_nx;
	logic              rise_nx;

	// Take a transaction unless a result is stuck in the output register
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks <= RST_START_LOW;
			cfg_q.release_ticks   <= RST_RELEASE;
			cfg_q.phase_timeout   <= RST_TIMEOUT;
			cfg_q.one_threshold   <= RST_THRESHOLD;
			cfg_q.max_rise_tenths <= RST_MAX_RISE;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_START_LOW: cfg_q.start_low_ticks <= cfg_data;
				CFG_RELEASE:   cfg_q.release_ticks   <= cfg_data[7:0];
				CFG_TIMEOUT:   cfg_q.phase_timeout   <= cfg_data[7:0];
				CFG_THRESHOLD: cfg_q.one_threshold   <= cfg_data[7:0];
				CFG_MAX_RISE:  cfg_q.max_rise_tenths <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	swhr_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.line_level    (line_level),
		.start_request (start_request),
		.cfg           (cfg_q),
		.res           (res)
	);

	swhr_decode u_decode (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.res                (res),
		.max_rise_tenths    (cfg_q.max_rise_tenths),
		.humidity           (hum_nx),
		.temperature_tenths (temp_nx),
		.checksum_ok        (chk_nx),
		.rise_plausible     (rise_nx)
	);

	// Output valid: set on accept, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= accept || (out_valid && out_stall);
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (accept) begin
			drive_enable       <= res.drive_enable;
			drive_level        <= res.drive_level;
			busy_res           <= res.busy;
			reading_done       <= res.done;
			humidity           <= hum_nx;
			temperature_tenths <= temp_nx;
			checksum_ok        <= chk_nx;
			rise_plausible     <= rise_nx;
		end
	end

endmodule

// File: sv/swhr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the single-wire humidity sensor reader, bound to the top level.
// Depends on single_wire_humidity_sensor_reader_top.
module swhr_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic drive_enable,
	input logic drive_level,
	input logic busy_res,
	input logic reading_done
);

	// An accepted transaction always yields a result next cycle
	a_accept_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted tick produced no result");

	// Input side never stalls while the output register is empty
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	// A driven high level needs the driver enabled
	a_level_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && drive_level) |-> drive_enable)
		else $error("drive level high while line released");

	// Driving and completion only happen during a reading
	a_busy_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (drive_enable || reading_done)) |-> busy_res)
		else $error("activity reported while idle");

	// Completion and driving never coincide
	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reading_done) |-> !drive_enable)
		else $error("reading completed on a driven tick");

endmodule

bind single_wire_humidity_sensor_reader_top swhr_checker u_swhr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.drive_enable (drive_enable),
	.drive_level  (drive_level),
	.busy_res     (busy_res),
	.reading_done (reading_done)
);
